### rtl/core/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, constants and helpers for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int IN_VALUE_W     = 32;
	localparam int ACTION_W       = 2;
	localparam int CHAR_W         = 8;
	localparam int CFG_W          = 8;
	localparam logic [CFG_W-1:0] BUF_SIZE_RST = 8'd16;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_HEX  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SDEC = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_UDEC = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_STRIP,
		ST_EMIT
	} i2a_state_t;

	// sequencer to digit unit
	typedef struct packed {
		logic load;    // take a new value
		logic hex;     // load as hex nibbles, else as binary for conversion
		logic neg;     // load the two's complement magnitude
		logic dabble;  // one shift-and-add-3 step
		logic shift;   // drop the top digit
	} i2a_cmd_t;

	// digits of 2^bits - 1: floor(bits*log10(2)) + 1, 2^bits never a power of ten
	function automatic int dec_digits(input int bits);
		return ((bits * 1233) >> 12) + 1;
	endfunction

	function automatic int hex_digits(input int bits);
		return (bits + 3) >> 2;
	endfunction

	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib, input logic upper);
		logic [CHAR_W-1:0] base;
		base = upper ? CHAR_UP_A : CHAR_LOW_A;
		if (nib < 4'd10) begin
			return CHAR_ZERO + CHAR_W'(nib);
		end
		return base + CHAR_W'(nib - 4'd10);
	endfunction

endpackage

### rtl/core/i2a_in_if.sv
// ----------------------------------------------------------------------------
// i2a_in_if
// Input item channel: valid/ready plus value and format controls.
// ----------------------------------------------------------------------------
interface i2a_in_if import i2a_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [ACTION_W-1:0]   action;
	logic [IN_VALUE_W-1:0] value;
	logic                  upper_case;
	logic                  strip_zeroes;

	modport source (output valid, action, value, upper_case, strip_zeroes, input ready);
	modport sink   (input valid, action, value, upper_case, strip_zeroes, output ready);
endinterface

### rtl/core/i2a_out_if.sv
// ----------------------------------------------------------------------------
// i2a_out_if
// Result item channel: one ASCII character per item.
// ----------------------------------------------------------------------------
interface i2a_out_if import i2a_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_out;
	logic              last;
	logic              error;

	modport source (output valid, char_out, last, error, input ready);
	modport sink   (input valid, char_out, last, error, output ready);
endinterface

### rtl/core/i2a_digit_unit.sv
// ----------------------------------------------------------------------------
// i2a_digit_unit
// Digit register with the shared shift-and-add-3 step and digit shifter.
// ----------------------------------------------------------------------------
module i2a_digit_unit import i2a_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  i2a_cmd_t              cmd,
	input  logic [VALUE_BITS-1:0] value,
	output logic [3:0]            top_nib
);
	localparam int NDIG = dec_digits(VALUE_BITS);
	localparam int DW   = NDIG * 4;
	localparam int HW   = hex_digits(VALUE_BITS) * 4;

	logic [DW-1:0]         dig_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [DW-1:0]         adj;

	// add 3 to every BCD digit of 5 or more
	always_comb begin
		for (int k = 0; k < NDIG; k++) begin
			adj[4*k +: 4] = (dig_q[4*k +: 4] >= 4'd5) ? dig_q[4*k +: 4] + 4'd3
			                                          : dig_q[4*k +: 4];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (cmd.hex) begin
				dig_q <= DW'(value) << (DW - HW);
			end else begin
				dig_q <= '0;
			end
			bin_q <= cmd.neg ? (VALUE_BITS'(0) - value) : value;
		end else if (cmd.dabble) begin
			dig_q <= {adj[DW-2:0], bin_q[VALUE_BITS-1]};
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
		end else if (cmd.shift) begin
			dig_q <= {dig_q[DW-5:0], 4'h0};
		end
	end

	assign top_nib = dig_q[DW-1 -: 4];

endmodule

### rtl/core/i2a_ctrl.sv
// ----------------------------------------------------------------------------
// i2a_ctrl
// Sequencer: conversion steps, leading zero strip, fit check, character out.
// ----------------------------------------------------------------------------
module i2a_ctrl import i2a_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ACTION_W-1:0] in_action,
	input  logic                in_msb,
	input  logic                in_upper,
	input  logic                in_strip,
	input  logic [3:0]          top_nib,
	output i2a_cmd_t            cmd,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [CHAR_W-1:0]   out_char,
	output logic                out_last,
	output logic                out_error
);
	localparam int NDIG  = dec_digits(VALUE_BITS);
	localparam int HEXD  = hex_digits(VALUE_BITS);
	localparam int CNT_W = $clog2(VALUE_BITS + 1);
	localparam int REM_W = $clog2(NDIG + 1);
	localparam int LEN_W = $clog2(NDIG + 2);
	localparam int FIT_W = ((LEN_W > CFG_W) ? LEN_W : CFG_W) + 1;

	i2a_state_t        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [REM_W-1:0]  rem_q;
	logic              neg_q, strip_q, upper_q, sign_pend_q, err_q;
	logic [CFG_W-1:0]  buf_size_q;

	logic              accept, is_hex, is_neg, strip_go, out_load;
	logic [LEN_W-1:0]  len;
	logic              no_fit;

	always_comb begin
		case (in_action)
			ACT_HEX:  begin is_hex = 1'b1; is_neg = 1'b0;   end
			ACT_SDEC: begin is_hex = 1'b0; is_neg = in_msb; end
			default:  begin is_hex = 1'b0; is_neg = 1'b0;   end
		endcase
	end

	assign strip_go = strip_q && (rem_q > REM_W'(1)) && (top_nib == 4'h0);
	assign len      = LEN_W'(rem_q) + LEN_W'(neg_q);
	assign no_fit   = (FIT_W'(len) + FIT_W'(1)) > FIT_W'(buf_size_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) begin
				state_d = is_hex ? ST_STRIP : ST_CONV;
			end
			ST_CONV:  if (cnt_q == CNT_W'(1)) begin
				state_d = ST_STRIP;
			end
			ST_STRIP: if (!strip_go) begin
				state_d = ST_EMIT;
			end
			ST_EMIT:  if (out_load && (err_q || (!sign_pend_q && rem_q == REM_W'(1)))) begin
				state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready   = 1'b0;
		out_load   = 1'b0;
		cmd        = '0;
		cmd.hex    = is_hex;
		cmd.neg    = is_neg;
		case (state_q)
			ST_IDLE:  begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CONV:  cmd.dabble = 1'b1;
			ST_STRIP: cmd.shift = strip_go;
			ST_EMIT:  begin
				out_load  = !out_valid || out_ready;
				cmd.shift = out_load && !err_q && !sign_pend_q;
			end
			default:  ;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			buf_size_q  <= BUF_SIZE_RST;
			out_valid   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				buf_size_q <= cfg_data;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_q       <= CNT_W'(VALUE_BITS);
			rem_q       <= is_hex ? REM_W'(HEXD) : REM_W'(NDIG);
			strip_q     <= is_hex ? in_strip : 1'b1;
			upper_q     <= in_upper;
			neg_q       <= is_neg;
			sign_pend_q <= is_neg;
		end else if (state_q == ST_CONV) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end else if (state_q == ST_STRIP) begin
			if (strip_go) begin
				rem_q <= rem_q - REM_W'(1);
			end else begin
				err_q <= no_fit;
			end
		end else if (out_load) begin
			if (sign_pend_q) begin
				sign_pend_q <= 1'b0;
			end else begin
				rem_q <= rem_q - REM_W'(1);
			end
		end
		if (out_load) begin
			out_error <= err_q;
			if (err_q) begin
				out_char <= CHAR_NONE;
				out_last <= 1'b1;
			end else if (sign_pend_q) begin
				out_char <= CHAR_MINUS;
				out_last <= 1'b0;
			end else begin
				out_char <= hex_char(top_nib, upper_q);
				out_last <= (rem_q == REM_W'(1));
			end
		end
	end

endmodule

### rtl/core/integer_to_ascii_formatter_top.sv
// First char: hex loads, strips leading zeros if asked, then emits; decimal loads,
//   runs VALUE_BITS shift-and-add-3 steps, strips leading zeros, then emits.
// One item in flight, input ready only when idle.
// Reset (arst_n low): idle, output empty, buffer_size back to 16.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats a value as hex, signed or unsigned decimal ASCII, one char per item.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top import i2a_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data,
	i2a_in_if.sink           din,
	i2a_out_if.source        dout
);
	// The digit unit holds a register of BCD/hex nibbles, top digit aligned to
	// the MSB end. Decimal uses one shift-and-add-3 step per input bit; the
	// same register then drops leading zeros one digit per cycle, and during
	// output shifts out one digit per char.

	i2a_cmd_t              cmd;
	logic [3:0]            top_nib;
	logic [VALUE_BITS-1:0] value_ext;

	// only the low VALUE_BITS bits take part
	assign value_ext = VALUE_BITS'(din.value);

	i2a_ctrl #(
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.in_action (din.action),
		.in_msb    (value_ext[VALUE_BITS-1]),
		.in_upper  (din.upper_case),
		.in_strip  (din.strip_zeroes),
		.top_nib   (top_nib),
		.cmd       (cmd),
		.out_ready (dout.ready),
		.out_valid (dout.valid),
		.out_char  (dout.char_out),
		.out_last  (dout.last),
		.out_error (dout.error)
	);

	// shared conversion unit
	i2a_digit_unit #(
		.VALUE_BITS (VALUE_BITS)
	) u_digit (
		.clk     (clk),
		.cmd     (cmd),
		.value   (value_ext),
		.top_nib (top_nib)
	);

endmodule

### rtl/core/i2a_checker.sv
// ----------------------------------------------------------------------------
// i2a_checker
// Port level checks for the formatter, bound to the top level.
// ----------------------------------------------------------------------------
module i2a_checker import i2a_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CHAR_W-1:0] out_char,
	input logic              out_last,
	input logic              out_error
);

	// an error item is alone: null char, marked last
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_error |-> out_last && out_char == CHAR_NONE)
		else $error("error item not last or not null");

	// no new item taken right after one is accepted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready while busy");

	// every normal char is a digit, hex letter or minus
	a_charset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_error |->
			(out_char >= 8'h30 && out_char <= 8'h39) ||
			(out_char >= 8'h41 && out_char <= 8'h46) ||
			(out_char >= 8'h61 && out_char <= 8'h66) ||
			out_char == CHAR_MINUS)
		else $error("char outside format set");

	// a minus is never the last char
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_error && out_char == CHAR_MINUS |-> !out_last)
		else $error("minus marked last");

	// stalled output holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
		else $error("output changed while stalled");

endmodule

bind integer_to_ascii_formatter_top i2a_checker u_i2a_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_char  (dout.char_out),
	.out_last  (dout.last),
	.out_error (dout.error)
);
